### rtl/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and helpers for the linear probing hash table.
// ---------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS     = 1024;
    localparam int KEY_BYTES = 8;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CAP_W     = 11;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 32;
    localparam int MOD_BITS  = 4;                  // quotient bits per cycle
    localparam int MOD_STEPS = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_MULT_LO = 9'h1B3;  // multiplier is 2^40 + 0x1B3
    localparam int          FNV_SHIFT   = 40;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_RD,
        ST_CHK,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_HASH,
        HS_MOD
    } hash_state_t;

    // zero every byte from the first zero byte on, and beyond KEY_BYTES
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

endpackage

### rtl/lpht_hash.sv
// ---------------------------------------------------------------------------
// lpht_hash
// FNV-1a over a normalized key (bytes sign-extended for the XOR), one byte
// a cycle, then start slot = hash mod capacity, four quotient bits a cycle.
// ---------------------------------------------------------------------------
module lpht_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    input  logic [lpht_pkg::CAP_W-1:0] cap,
    output logic                       done,
    output logic [lpht_pkg::IDX_W-1:0] slot
);
    import lpht_pkg::*;

    hash_state_t          hs_reg, hs_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [63:0]          h_reg, h_next;
    logic [CAP_W-1:0]     rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;

    logic [63:0]          x;
    logic [63:0]          prod;
    logic [CAP_W:0]       t;
    logic [CAP_W-1:0]     r;

    assign x    = h_reg ^ {{56{key_reg[7]}}, key_reg[7:0]};
    assign prod = (x << FNV_SHIFT) + 64'(x * FNV_MULT_LO);

    // restoring remainder, MOD_BITS dividend bits per cycle
    always_comb
    begin
        r = rem_reg;
        t = '0;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {r, h_reg[63-i]};
            if (t >= {1'b0, cap})
                t = t - {1'b0, cap};
            r = t[CAP_W-1:0];
        end
    end

    always_comb
    begin
        hs_next   = hs_reg;
        key_next  = key_reg;
        h_next    = h_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        slot_next = slot_reg;
        unique case (hs_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    h_next   = FNV_BASIS;
                    hs_next  = HS_HASH;
                end
            end
            HS_HASH:
            begin
                if (key_reg[7:0] == 8'd0)
                begin
                    rem_next = '0;
                    cnt_next = '0;
                    hs_next  = HS_MOD;
                end
                else
                begin
                    h_next   = prod;
                    key_next = key_reg >> 8;
                end
            end
            HS_MOD:
            begin
                rem_next = r;
                h_next   = h_reg << MOD_BITS;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    done_next = 1'b1;
                    slot_next = r[IDX_W-1:0];
                    hs_next   = HS_IDLE;
                end
            end
            default: hs_next = HS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg   <= HS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            hs_reg   <= hs_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        h_reg    <= h_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        slot_reg <= slot_next;
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

### rtl/linear_probe_hash_table_core.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing key/value table, sign-extending FNV-1a, linear probing.
// ---------------------------------------------------------------------------
// One item is handled at a time. Each item is hashed one byte a cycle over
// the key bytes before the first zero, reduced modulo capacity, and then
// probed slot by slot, with one read and one compare of the slot memory per
// slot; an item of an unknown kind goes straight to the result as a miss.
// After reset the slot flags are cleared one slot a cycle, and no item is
// accepted until then. Capacity lies at address 0.
module linear_probe_hash_table_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key[63:0], value[95:64]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // read_value[31:0]
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lpht_pkg::*;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [CAP_W-1:0]     cap_eff;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [1:0]           kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CAP_W-1:0]     n_reg, n_next;
    logic [CAP_W-1:0]     n_inc;
    logic [CAP_W-1:0]     idx_inc;
    logic [1:0]           stat_reg, stat_next;
    logic [VAL_W-1:0]     rv_reg, rv_next;
    logic                 mval_reg, mval_next;
    logic [1:0]           mstat_reg, mstat_next;
    logic [VAL_W-1:0]     mrv_reg, mrv_next;

    logic [KEY_W-1:0]     key_in;
    logic                 hash_start;
    logic                 hash_done;
    logic [IDX_W-1:0]     hash_slot;

    logic [1:0]           flags_mem [SLOTS];   // {used, present}
    logic [KEY_W+VAL_W-1:0] data_mem [SLOTS];  // {key, value}
    logic [1:0]           flags_q;
    logic [KEY_W+VAL_W-1:0] data_q;
    logic                 fl_we;
    logic [IDX_W-1:0]     fl_addr;
    logic [1:0]           fl_wdata;
    logic                 dt_we;
    logic [VAL_W-1:0]     dt_wval;

    logic                 in_acc;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {{(32-CAP_W){1'b0}}, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_W'(SLOTS);
        else if (cfg_wr)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CAP_W'(1);
        else if (cap_reg > CAP_W'(SLOTS))
            cap_eff = CAP_W'(SLOTS);
        else
            cap_eff = cap_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mrv_reg;
    assign m_tuser  = mstat_reg;

    // the hash unit latches the key at the accepting edge
    assign key_in = normalize_key(s_tdata[KEY_W-1:0]);

    lpht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_in),
        .cap   (cap_eff),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    assign n_inc   = n_reg + 1'b1;
    assign idx_inc = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        stat_next  = stat_reg;
        rv_next    = rv_reg;
        mval_next  = mval_reg;
        mstat_next = mstat_reg;
        mrv_next   = mrv_reg;
        hash_start = 1'b0;
        fl_we      = 1'b0;
        fl_addr    = idx_reg;
        fl_wdata   = 2'b00;
        dt_we      = 1'b0;
        dt_wval    = val_reg;

        if (mval_reg && m_tready)
            mval_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                fl_we    = 1'b1;
                fl_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {IDX_W{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next = s_tuser;
                    key_next  = key_in;
                    val_next  = s_tdata[KEY_W +: VAL_W];
                    rv_next   = '0;
                    n_next    = '0;
                    if (s_tuser == KIND_SET)
                        stat_next = STAT_FULL;
                    else
                        stat_next = STAT_MISS;
                    if (s_tuser == KIND_LOOKUP || s_tuser == KIND_SET
                        || s_tuser == KIND_REMOVE)
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_slot;
                    state_next = ST_RD;
                end
            end
            ST_RD:
                state_next = ST_CHK;
            ST_CHK:
            begin
                state_next = ST_RESULT;
                if (!flags_q[1])
                begin
                    if (kind_reg == KIND_SET)
                    begin
                        fl_we     = 1'b1;
                        fl_wdata  = 2'b11;
                        dt_we     = 1'b1;
                        stat_next = STAT_OK;
                    end
                end
                else if (data_q[KEY_W+VAL_W-1:VAL_W] == key_reg)
                begin
                    stat_next = STAT_OK;
                    case (kind_reg)
                        KIND_LOOKUP:
                        begin
                            if (flags_q[0])
                                rv_next = data_q[VAL_W-1:0];
                            else
                                stat_next = STAT_MISS;
                        end
                        KIND_SET:
                        begin
                            fl_we    = 1'b1;
                            fl_wdata = 2'b11;
                            dt_we    = 1'b1;
                        end
                        default:
                        begin
                            fl_we    = 1'b1;
                            fl_wdata = 2'b10;
                        end
                    endcase
                end
                else if (n_inc < cap_eff)
                begin
                    n_next     = n_inc;
                    idx_next   = (idx_inc >= cap_eff) ? '0 : idx_inc[IDX_W-1:0];
                    state_next = ST_RD;
                end
            end
            ST_RESULT:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next  = 1'b1;
                    mstat_next = stat_reg;
                    mrv_next   = rv_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        stat_reg  <= stat_next;
        rv_reg    <= rv_next;
        mstat_reg <= mstat_next;
        mrv_reg   <= mrv_next;
    end

    // slot flags
    always_ff @(posedge clk)
    begin
        if (fl_we)
            flags_mem[fl_addr] <= fl_wdata;
        if (state_reg == ST_RD)
            flags_q <= flags_mem[idx_reg];
    end

    // slot key and value
    always_ff @(posedge clk)
    begin
        if (dt_we)
            data_mem[idx_reg] <= {key_reg, dt_wval};
        if (state_reg == ST_RD)
            data_q <= data_mem[idx_reg];
    end

    a_probe_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> ({1'b0, idx_reg} < cap_eff))
        else $error("probe slot beyond capacity");

    a_probe_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (n_reg < cap_eff))
        else $error("probe walk longer than capacity");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero value on a miss");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!fl_we && !dt_we))
        else $error("slot memory written while idle");

endmodule
